// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/asms_pkg.sv =====
// ----------------------------------------------------------------------------
// asms_pkg
// Types and fixed result field widths shared by the statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asms_pkg;

    // Result field widths, lowest field of the output word first.
    localparam int OUT_SUM_W   = 26;
    localparam int OUT_MEAN_W  = 23;
    localparam int OUT_ABOVE_W = 11;
    localparam int OUT_RANGE_W = 16;
    localparam int OUT_COUNT_W = 11;
    localparam int OUT_OVF_W   = 1;
    localparam int OUT_TDATA_W = 88;

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_PASS
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_done;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/asms_ctrl.sv =====
// ----------------------------------------------------------------------------
// asms_ctrl
// Controller: loads samples, then runs the closing pass and releases the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asms_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    output asms_pkg::t_cmd     o_cmd,
    input  asms_pkg::t_sts     i_sts
);
    import asms_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_PASS;
            end
            ST_PASS: begin
                if (i_sts.pass_done && !i_sts.div_busy && i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/asms_dp.sv =====
// ----------------------------------------------------------------------------
// asms_dp
// Datapath: sample memory, running statistics, closing pass, divider, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asms_dp #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    input  asms_pkg::t_cmd                     i_cmd,
    output asms_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [asms_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import asms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int PROD_W = SAMPLE_BITS + CNT_W + 1;
    localparam int DEN_W  = CNT_W + 1;
    localparam int NUM_W  = SUM_W + 9;
    localparam int QCNT_W = $clog2(NUM_W + 1);

    localparam logic [CNT_W-1:0]       MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [SAMPLE_BITS-1:0] S_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Sample memory.
    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    // Running statistics of the current set.
    logic [CNT_W-1:0]              r_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic                          r_ovf;

    // Closing pass.
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_issue;
    logic                     r_rd_v;
    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]         r_above;

    // Divider.
    logic              r_neg;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QCNT_W-1:0] r_qcnt;
    logic              r_div_busy;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                          w_store;
    logic                          w_rd_en;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [SUM_W-1:0]              w_mag;
    logic [NUM_W-1:0]              w_num_init;
    logic [DEN_W:0]                w_rem_sh;
    logic                          w_ge;
    logic signed [NUM_W:0]         w_mean;
    logic [SAMPLE_BITS:0]          w_range;

    assign w_sample = $signed(i_sample);
    assign w_store  = i_cmd.load && (r_count < MAX_CNT);
    assign w_rd_en  = (r_issue != r_n);

    // Memory write on load, registered read during the closing pass.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_issue[AW-1:0]];
        end
    end

    // Running count, sum, minimum, maximum and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= S_MAX;
            r_max   <= S_MIN;
            r_ovf   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= S_MAX;
            r_max   <= S_MIN;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(w_sample);
                if (w_sample < r_min) begin
                    r_min <= w_sample;
                end
                if (w_sample > r_max) begin
                    r_max <= w_sample;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Closing pass: read each stored sample, multiply by the count, compare with the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_issue  <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            r_above  <= '0;
        end else if (i_cmd.prep) begin
            r_n      <= r_count;
            r_issue  <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            r_above  <= '0;
        end else begin
            if (w_rd_en) begin
                r_issue <= r_issue + CNT_W'(1);
            end
            r_rd_v   <= w_rd_en;
            r_prod_v <= r_rd_v;
            if (r_prod_v && (r_prod >= PROD_W'(r_sum))) begin
                r_above <= r_above + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(r_rd_data) * $signed({1'b0, r_n});
    end

    // Divider set-up: numerator is 200 * |sum| + n, denominator 2 * n.
    assign w_mag      = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_num_init = NUM_W'(w_mag) * NUM_W'(200) + NUM_W'(r_count);

    // Restoring division, one quotient bit per cycle; r_num ends as the quotient.
    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_qcnt     <= '0;
        end else if (i_cmd.prep) begin
            r_div_busy <= 1'b1;
            r_qcnt     <= QCNT_W'(NUM_W);
        end else if (r_div_busy) begin
            r_qcnt     <= r_qcnt - QCNT_W'(1);
            r_div_busy <= (r_qcnt != QCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_neg <= r_sum[SUM_W-1];
            r_num <= w_num_init;
            r_den <= {r_count, 1'b0};
            r_rem <= '0;
        end else if (r_div_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
        end
    end

    // Result fields.
    assign w_mean  = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    assign w_range = {r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min};

    // Output register, freed when the receiver takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {r_ovf,
                           OUT_COUNT_W'(r_count),
                           OUT_RANGE_W'(w_range),
                           OUT_ABOVE_W'(r_above),
                           OUT_MEAN_W'(w_mean),
                           OUT_SUM_W'(r_sum)};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_sts.pass_done = !w_rd_en && !r_rd_v && !r_prod_v;
    assign o_sts.div_busy  = r_div_busy;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/array_sum_mean_range_stats_top.sv =====
// ----------------------------------------------------------------------------
// array_sum_mean_range_stats_top
// Sum, rounded mean x100, count at or above the mean, and range of a sample set.
// ----------------------------------------------------------------------------
// Samples arrive on the slave stream, one item per cycle while tready is high;
// tlast marks the final sample of a set. Samples beyond MAX_SAMPLES are dropped
// and flagged. After the last sample the input closes: a set-up state, then
// the closing pass re-reads the n stored samples from the memory through a
// three-stage read, multiply and compare pipeline, while a restoring divider
// works out the mean one quotient bit per cycle, NUM_W = SAMPLE_BITS +
// clog2(MAX_SAMPLES+1) + 9 bits in all (36 at the defaults). The result item is
// written to the output register once the pass and the division are done; the
// input stays closed until then, so a new set cannot load while the pass still
// reads the memory through its single read port. Once the result sits in the
// output register the next set loads at once; if the receiver stalls, the
// following set closes but waits in its pass until the register is free.
// Reset empties the set and drops any held result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module array_sum_mean_range_stats_top #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // sample (SAMPLE_BITS, signed), zero padding up to a whole byte
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // is_last
    input  wire logic                                  i_s_axis_tlast,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // total_sum[25:0], mean_x100[48:26], at_or_above_mean[59:49],
    // value_range[75:60], sample_count[86:76], overflowed[87]
    output logic [asms_pkg::OUT_TDATA_W-1:0]           o_m_axis_tdata
);
    import asms_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    asms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    asms_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // The input closes once the last sample of a set is taken.
    `ASSERT_NEXT(a_close_on_last, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready, "input still open after last sample")
    // No sample is loaded while the divider still works on the previous set.
    `ASSERT_SAME(a_load_div_idle, i_clk, i_rst_n, w_cmd.load, !w_sts.div_busy, "sample loaded during division")
    // A released result shows on the output in the next cycle.
    `ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, w_cmd.emit, o_m_axis_tvalid, "released result not presented")

endmodule

`default_nettype wire
